/* design/hsfd_pkg.sv */
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and arithmetic helpers of the humidity sensor
// frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [15:0] TEMP_SCALE  = 16'd35000;
	localparam logic [15:0] HUM_SCALE   = 16'd20000;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
	localparam logic [4:0]  TRIM_MID    = 5'd10;
	localparam logic [4:0]  TRIM_RESET  = 5'd10;

	localparam logic CFG_TEMP_TRIM = 1'b0;
	localparam logic CFG_HUM_TRIM  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TEMP_CRC = 2'd1,
		ST_HUM_CRC  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
		status_t     status;
	} frame_res_t;

	function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// round(raw * k / 131070): x / 2 = a * 65536 + b = a * 65535 + (a + b),
	// and a + b stays below twice 65535
	function automatic logic [14:0] scale_round(logic [15:0] raw, logic [15:0] k);
		logic [31:0] x;
		logic [14:0] a;
		logic [15:0] b;
		logic [16:0] s;
		x = ({16'b0, raw} * {16'b0, k}) + 32'd65535;
		a = x[31:17];
		b = x[16:1];
		s = {2'b0, a} + {1'b0, b};
		return a + 15'(s >= 17'd65535);
	endfunction

endpackage

/* design/hsfd_frame.sv */
// ----------------------------------------------------------------------------
// hsfd_frame
// Input register, byte sequencing and CRC-8 check; hands one assembled frame
// to the conversion stage after the sixth byte.
// ----------------------------------------------------------------------------
module hsfd_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_start,
	output logic                res_valid,
	input  logic                res_ready,
	output hsfd_pkg::frame_res_t res
);
	import hsfd_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	pos_t       pos_q, pos_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] hi_q, hi_d;
	logic [15:0] tword_q, tword_d;
	logic [15:0] hword_q, hword_d;
	status_t    err_q, err_d;
	logic       emit;

	logic       s2_free;
	logic       proceed;
	pos_t       eff_pos;
	logic [7:0] crc_base;
	status_t    err_base;
	logic       active;

	frame_res_t res_s2;
	logic       vld_s2;

	assign s2_free  = !vld_s2 || res_ready;
	assign proceed  = vld_s1 && s2_free;
	assign in_ready = !vld_s1 || s2_free;

	assign active   = start_s1 || (pos_q != POS_T_HI);
	assign eff_pos  = start_s1 ? POS_T_HI : pos_q;
	assign crc_base = start_s1 ? CRC_INIT : crc_q;
	assign err_base = start_s1 ? ST_OK : err_q;

	always_comb begin
		pos_d = pos_q;
		if (active) begin
			unique case (eff_pos)
				POS_T_HI:  pos_d = POS_T_LO;
				POS_T_LO:  pos_d = POS_T_CRC;
				POS_T_CRC: pos_d = POS_H_HI;
				POS_H_HI:  pos_d = POS_H_LO;
				POS_H_LO:  pos_d = POS_H_CRC;
				default:   pos_d = POS_T_HI;
			endcase
		end else begin
			pos_d = POS_T_HI;
		end
	end

	always_comb begin
		crc_d   = crc_q;
		hi_d    = hi_q;
		tword_d = tword_q;
		hword_d = hword_q;
		err_d   = err_q;
		emit    = 1'b0;
		if (active) begin
			err_d = err_base;
			unique case (eff_pos)
				POS_T_HI, POS_H_HI: begin
					crc_d = crc_feed(CRC_INIT, byte_s1);
					hi_d  = byte_s1;
				end
				POS_T_LO: begin
					crc_d   = crc_feed(crc_base, byte_s1);
					tword_d = {hi_q, byte_s1};
				end
				POS_H_LO: begin
					crc_d   = crc_feed(crc_base, byte_s1);
					hword_d = {hi_q, byte_s1};
				end
				POS_T_CRC: begin
					if (crc_base != byte_s1 && err_base == ST_OK) begin
						err_d = ST_TEMP_CRC;
					end
					crc_d = CRC_INIT;
				end
				default: begin
					if (crc_base != byte_s1 && err_base == ST_OK) begin
						err_d = ST_HUM_CRC;
					end
					crc_d = CRC_INIT;
					emit  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= in_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_T_HI;
			crc_q   <= CRC_INIT;
			err_q   <= ST_OK;
			hi_q    <= '0;
			tword_q <= '0;
			hword_q <= '0;
		end else if (proceed) begin
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			err_q   <= err_d;
			hi_q    <= hi_d;
			tword_q <= tword_d;
			hword_q <= hword_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= proceed && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit) begin
			res_s2.raw_temperature <= tword_q;
			res_s2.raw_humidity    <= hword_q;
			res_s2.status          <= err_d;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

/* design/hsfd_conv.sv */
// ----------------------------------------------------------------------------
// hsfd_conv
// Fixed-point conversion of the raw words to centi-units, trim, and the
// result register.
// ----------------------------------------------------------------------------
module hsfd_conv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  hsfd_pkg::frame_res_t res,
	input  logic [4:0]           temp_trim,
	input  logic [4:0]           hum_trim,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [14:0]          temperature_centi,
	output logic [13:0]          humidity_centi,
	output logic [15:0]          raw_temperature,
	output logic [15:0]          raw_humidity,
	output logic [1:0]           status
);
	import hsfd_pkg::*;

	function automatic logic signed [15:0] apply_trim(logic signed [15:0] v,
		logic [4:0] trim);
		logic signed [15:0] t100;
		t100 = $signed({4'b0, 12'({7'b0, trim} * 12'd100)});
		if (trim >= TRIM_MID) begin
			return v + t100 - 16'sd1000;
		end else if (v <= t100) begin
			return '0;
		end
		return v - t100;
	endfunction

	logic        out_vld_q;
	logic [14:0] q_t;
	logic [14:0] q_h;
	logic signed [15:0] tc;
	logic signed [15:0] hc;
	logic signed [15:0] tc_trim;
	logic signed [15:0] hc_trim;
	logic        ok;

	assign res_ready = !out_vld_q || out_ready;

	assign q_t     = scale_round(res.raw_temperature, TEMP_SCALE);
	assign q_h     = scale_round(res.raw_humidity, HUM_SCALE);
	assign tc      = $signed({1'b0, q_t}) - TEMP_OFFSET;
	assign hc      = $signed({1'b0, q_h});
	assign tc_trim = apply_trim(tc, temp_trim);
	assign hc_trim = apply_trim(hc, hum_trim);
	assign ok      = (res.status == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			temperature_centi <= ok ? tc_trim[14:0] : '0;
			humidity_centi    <= ok ? hc_trim[13:0] : '0;
			raw_temperature   <= res.raw_temperature;
			raw_humidity      <= res.raw_humidity;
			status            <= res.status;
		end
	end

	assign out_valid = out_vld_q;

endmodule

/* design/humidity_sensor_frame_decoder.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes six-byte temperature/humidity responses with CRC-8 checking and
// converts the readings to trimmed centi-units.
// ----------------------------------------------------------------------------
// One response byte is taken every clock unless output back-pressure stalls
// the input; the per-byte CRC-8 update in the frame stage sets that rate.
// Once its sixth byte is taken, a result passes the input register, the frame
// stage and the result register in turn. Only a request carrying tuser high
// starts a frame; a stray byte outside a frame is dropped. Trims are written
// through the cfg channel, which is always ready.
module humidity_sensor_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
	                                    // [44:29] raw_temperature, [60:45] raw_humidity
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import hsfd_pkg::*;

	logic [4:0]  temp_trim_q;
	logic [4:0]  hum_trim_q;
	logic        res_valid;
	logic        res_ready;
	frame_res_t  res;
	logic [14:0] temperature_centi;
	logic [13:0] humidity_centi;
	logic [15:0] raw_temperature;
	logic [15:0] raw_humidity;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q <= TRIM_RESET;
			hum_trim_q  <= TRIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TEMP_TRIM: temp_trim_q <= cfg_data;
				CFG_HUM_TRIM:  hum_trim_q  <= cfg_data;
				default:       temp_trim_q <= temp_trim_q;
			endcase
		end
	end

	hsfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	hsfd_conv u_conv (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.res               (res),
		.temp_trim         (temp_trim_q),
		.hum_trim          (hum_trim_q),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.raw_temperature   (raw_temperature),
		.raw_humidity      (raw_humidity),
		.status            (m_axis_tuser)
	);

	assign m_axis_tdata = {3'b0, raw_humidity, raw_temperature, humidity_centi,
		temperature_centi};

endmodule

/* design/hsfd_checker.sv */
// ----------------------------------------------------------------------------
// hsfd_checker
// Port-level checks of the frame decoder's result stream.
// ----------------------------------------------------------------------------
module hsfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import hsfd_pkg::*;

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[28:0] == '0)
		else $error("converted values not zero on CRC error");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("status code out of range");

	a_temp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_OK |-> $signed(m_axis_tdata[14:0]) >= -15'sd4500)
		else $error("temperature below conversion floor");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the humidity sensor frame decoder. Response bytes
// go in as stream requests, and a bit-true predictor works out the reading
// that each completed frame should give. A short scripted part covers the
// extreme words, each CRC status, an aborted frame and a stray byte. Random
// frames, broken frames and noise follow over a sweep of trim settings and
// sender and receiver stall ratios.
// ----------------------------------------------------------------------------
module tb;
	import hsfd_pkg::*;

	typedef struct packed {
		logic [14:0] temp_c;
		logic [13:0] hum_c;
		logic [15:0] raw_t;
		logic [15:0] raw_h;
		status_t     status;
	} reading_t;

	typedef struct packed {
		logic [7:0] b;
		logic       start;
		logic       typed;
		reading_t   want;
	} script_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_index     = CFG_TEMP_TRIM;
	logic [4:0]  cfg_data      = 5'd0;

	humidity_sensor_frame_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// decoder state as predicted
	pos_t        frame_pos  = POS_T_HI;
	logic [7:0]  frame_crc  = CRC_INIT;
	logic [7:0]  hi_byte    = 8'h00;
	logic [15:0] t_word     = 16'h0000;
	logic [15:0] h_word     = 16'h0000;
	status_t     frame_err  = ST_OK;
	logic [4:0]  trim_t     = TRIM_RESET;
	logic [4:0]  trim_h     = TRIM_RESET;

	reading_t    pending_readings[$];
	int          send_idle_pct  = 25;
	int          recv_idle_pct  = 69;
	int          phase_items;
	int          bytes_sent;
	int          readings_checked;
	int          crc_flagged;
	int          mismatches;

	script_row_t script [27] = '{
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hA5, 1'b1, 1'b0, '0},
		'{8'h3C, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h81, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h81, 1'b0, 1'b1, '{-15'sd4500, 14'd0, 16'h0000, 16'h0000, ST_OK}},
		'{8'hFF, 1'b1, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hAC, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hAC, 1'b0, 1'b1, '{15'd13000, 14'd10000, 16'hFFFF, 16'hFFFF, ST_OK}},
		'{8'hBE, 1'b1, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hBE, 1'b0, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{15'd0, 14'd0, 16'hBEEF, 16'hBEEF, ST_TEMP_CRC}},
		'{8'hBE, 1'b1, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h92, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{15'd0, 14'd0, 16'hBEEF, 16'h0000, ST_HUM_CRC}}
	};

	logic [4:0] sweep_t [6] = '{5'd0, 5'd31, 5'd20, 5'd9, 5'd0, 5'd0};
	logic [4:0] sweep_h [6] = '{5'd31, 5'd0, 5'd9, 5'd20, 5'd0, 5'd0};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic int centi(input logic [15:0] raw, input longint unsigned full);
		longint unsigned n;
		n = longint'(raw) * full * 2 + 65535;
		return int'(n / 131070);
	endfunction

	function automatic int trimmed(input int v, input logic [4:0] trim);
		int t;
		t = int'(trim);
		if (trim >= TRIM_MID) begin
			return v + (t - int'(TRIM_MID)) * 100;
		end
		if (v <= t * 100) begin
			return 0;
		end
		return v - t * 100;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic start, output bit got,
		output reading_t rd);
		int tc;
		int hc;
		got = 1'b0;
		rd = '0;
		if (start) begin
			frame_pos = POS_T_HI;
			frame_crc = CRC_INIT;
			frame_err = ST_OK;
		end else if (frame_pos == POS_T_HI) begin
			return;
		end
		case (frame_pos)
			POS_T_HI: begin
				frame_crc = crc8_step(CRC_INIT, b);
				hi_byte = b;
				frame_pos = POS_T_LO;
			end
			POS_H_HI: begin
				frame_crc = crc8_step(CRC_INIT, b);
				hi_byte = b;
				frame_pos = POS_H_LO;
			end
			POS_T_LO: begin
				frame_crc = crc8_step(frame_crc, b);
				t_word = {hi_byte, b};
				frame_pos = POS_T_CRC;
			end
			POS_T_CRC: begin
				if (frame_crc != b && frame_err == ST_OK) frame_err = ST_TEMP_CRC;
				frame_crc = CRC_INIT;
				frame_pos = POS_H_HI;
			end
			POS_H_LO: begin
				frame_crc = crc8_step(frame_crc, b);
				h_word = {hi_byte, b};
				frame_pos = POS_H_CRC;
			end
			default: begin
				if (frame_crc != b && frame_err == ST_OK) frame_err = ST_HUM_CRC;
				frame_crc = CRC_INIT;
				frame_pos = POS_T_HI;
				tc = 0;
				hc = 0;
				if (frame_err == ST_OK) begin
					tc = trimmed(centi(t_word, 17500) - 4500, trim_t);
					hc = trimmed(centi(h_word, 10000), trim_h);
				end
				rd.temp_c = tc[14:0];
				rd.hum_c = hc[13:0];
				rd.raw_t = t_word;
				rd.raw_h = h_word;
				rd.status = frame_err;
				got = 1'b1;
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input logic start, input bit typed,
		input reading_t typed_want);
		bit got;
		reading_t rd;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b, start, got, rd);
		if (got) pending_readings.push_back(typed ? typed_want : rd);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
		input logic [7:0] t_flip, input logic [7:0] h_flip);
		logic [7:0] tcrc;
		logic [7:0] hcrc;
		tcrc = crc8_step(crc8_step(CRC_INIT, tw[15:8]), tw[7:0]) ^ t_flip;
		hcrc = crc8_step(crc8_step(CRC_INIT, hw[15:8]), hw[7:0]) ^ h_flip;
		push_byte(tw[15:8], 1'b1, 1'b0, '0);
		push_byte(tw[7:0], 1'b0, 1'b0, '0);
		push_byte(tcrc, 1'b0, 1'b0, '0);
		push_byte(hw[15:8], 1'b0, 1'b0, '0);
		push_byte(hw[7:0], 1'b0, 1'b0, '0);
		push_byte(hcrc, 1'b0, 1'b0, '0);
		phase_items += 6;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(16'h1800));
			3: return 16'($urandom_range(16'hFFFF, 16'hE000));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_unit();
		int kind;
		int n;
		logic [7:0] t_flip;
		logic [7:0] h_flip;
		kind = $urandom_range(99);
		if (kind < 75) begin
			t_flip = ($urandom_range(99) < 10) ? 8'($urandom_range(255, 1)) : 8'h00;
			h_flip = ($urandom_range(99) < 10) ? 8'($urandom_range(255, 1)) : 8'h00;
			send_frame(pick_word(), pick_word(), t_flip, h_flip);
		end else if (kind < 85) begin
			n = $urandom_range(5, 1);
			push_byte(8'($urandom), 1'b1, 1'b0, '0);
			repeat (n - 1) push_byte(8'($urandom), 1'b0, 1'b0, '0);
			phase_items += n;
		end else if (kind < 93) begin
			repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0, 1'b0, '0);
		end else begin
			push_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
			phase_items++;
		end
	endtask

	task automatic write_trim(input logic idx, input logic [4:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_TEMP_TRIM) trim_t = val;
		else trim_h = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every reading is back and the pipeline has flushed
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				$error("reading with none outstanding: tdata 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				check_field("temperature_centi", want.temp_c, m_axis_tdata[14:0]);
				check_field("humidity_centi", want.hum_c, m_axis_tdata[28:15]);
				check_field("raw_temperature", want.raw_t, m_axis_tdata[44:29]);
				check_field("raw_humidity", want.raw_h, m_axis_tdata[60:45]);
				check_field("status", want.status, m_axis_tuser);
				readings_checked++;
				if (want.status != ST_OK) crc_flagged++;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			push_byte(script[i].b, script[i].start, script[i].typed, script[i].want);
		end
		drain();

		for (int p = 0; p < 6; p++) begin
			send_idle_pct = (p < 2) ? 25 : (p < 4) ? 69 : 0;
			recv_idle_pct = (p < 2) ? 69 : (p < 4) ? 25 : 0;
			if (p == 4) begin
				write_trim(CFG_TEMP_TRIM, 5'($urandom_range(31)));
				write_trim(CFG_HUM_TRIM, 5'($urandom_range(31)));
			end else begin
				write_trim(CFG_TEMP_TRIM, sweep_t[p]);
				write_trim(CFG_HUM_TRIM, sweep_h[p]);
			end
			phase_items = 0;
			while (phase_items < 275) random_unit();
			// close on a whole frame so no partial one spans a trim change
			send_frame(pick_word(), pick_word(), 8'h00, 8'h00);
			drain();
		end

		$display("tb: %0d bytes sent, %0d readings checked, %0d with a CRC status",
			bytes_sent, readings_checked, crc_flagged);
		$display("tb: trims swept 0..31 on both channels, stalls on either side and none");
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

/* humidity_sensor_frame_decoder.f */
design/hsfd_pkg.sv
design/hsfd_frame.sv
design/hsfd_conv.sv
design/humidity_sensor_frame_decoder.sv
design/hsfd_checker.sv
test/tb.sv
